// File: hdl/ctsd_pkg.sv
// ----------------------------------------------------------------------------
// ctsd_pkg
// Shared types, command codes and digit helpers for the clock time-set and
// display controller.
// ----------------------------------------------------------------------------
package ctsd_pkg;

   typedef enum logic [2:0] {
      CMD_TICK   = 3'd0,
      CMD_SET    = 3'd1,
      CMD_UP     = 3'd2,
      CMD_DOWN   = 3'd3,
      CMD_FORMAT = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      EDIT_IDLE      = 2'd0,
      EDIT_MIN_UNITS = 2'd1,
      EDIT_MIN_TENS  = 2'd2,
      EDIT_HOURS     = 2'd3
   } edit_type;

   typedef enum logic [1:0] {
      LAMP_OFF = 2'd0,
      LAMP_AM  = 2'd1,
      LAMP_PM  = 2'd2
   } lamp_type;

   localparam logic [7:0] DP_BIT       = 8'h80;
   localparam logic [4:0] HOUR_MAX     = 5'd23;
   localparam logic [4:0] HOUR_RESET   = 5'd12;
   localparam logic [4:0] HOUR_NOON    = 5'd12;
   localparam logic [5:0] MINUTE_MAX   = 6'd59;
   localparam logic [3:0] UNITS_MAX    = 4'd9;
   localparam logic [2:0] TENS_MAX     = 3'd5;

   typedef struct packed {
      logic [2:0] cmd;
      logic [4:0] rtc_hour;
      logic [5:0] rtc_minute;
   } req_type;

   typedef struct packed {
      logic [7:0] seg_minute_units;
      logic [7:0] seg_minute_tens;
      logic [7:0] seg_hour_units;
      logic [7:0] seg_hour_tens;
      logic [1:0] ampm_lamp;
      logic [1:0] edit_position;
      logic       rtc_write;
      logic [5:0] rtc_hour_bcd;
      logic [6:0] rtc_minute_bcd;
   } rsp_type;

   typedef struct packed {
      logic [3:0] minute_units;
      logic [2:0] minute_tens;
      logic [4:0] hour_value;
      edit_type   edit_step;
      logic       twelve_hour_mode;
   } clock_state_type;

   // updated state plus the rtc write that the request caused
   typedef struct packed {
      clock_state_type state;
      logic            rtc_write;
      logic [5:0]      rtc_hour_bcd;
      logic [6:0]      rtc_minute_bcd;
   } upd_type;

   // tens digit of a value up to 63 by compare chain
   function automatic logic [2:0] tens_of(input logic [5:0] v);
      logic [2:0] t;
      if (v >= 6'd60)      t = 3'd6;
      else if (v >= 6'd50) t = 3'd5;
      else if (v >= 6'd40) t = 3'd4;
      else if (v >= 6'd30) t = 3'd3;
      else if (v >= 6'd20) t = 3'd2;
      else if (v >= 6'd10) t = 3'd1;
      else                 t = 3'd0;
      return t;
   endfunction

   function automatic logic [3:0] units_of(input logic [5:0] v);
      logic [2:0] t;
      logic [5:0] r;
      t = tens_of(v);
      r = v - ((6'(t) << 3) + (6'(t) << 1));
      return r[3:0];
   endfunction

   function automatic logic [7:0] seg_code(input logic [3:0] d);
      logic [7:0] s;
      case (d)
         4'd0:    s = 8'd63;
         4'd1:    s = 8'd6;
         4'd2:    s = 8'd91;
         4'd3:    s = 8'd79;
         4'd4:    s = 8'd102;
         4'd5:    s = 8'd109;
         4'd6:    s = 8'd125;
         4'd7:    s = 8'd71;
         4'd8:    s = 8'd127;
         4'd9:    s = 8'd103;
         default: s = 8'd0;
      endcase
      return s;
   endfunction

endpackage

// File: hdl/clock_time_set_and_display.sv
// ----------------------------------------------------------------------------
// clock_time_set_and_display
// Clock time-set and display controller: one command per request, one
// display/rtc-write response per request.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command (tick, set, up, down, format toggle) with the
//   rtc hour and minute in binary. rsp_* returns four seven-segment codes,
//   the am/pm lamp, the edit position and an optional bcd write to the rtc.
//   A request is taken when req_valid is high and req_stall is low; a
//   response is taken when rsp_valid is high and rsp_stall is low.
//   Path: the request lands in an input register, and the clock state and
//   the response register update together when the request advances, which
//   a receiver stall can hold off. Throughput is one request per cycle while
//   rsp_stall stays low, set by the single state update between the registers.
//   When the receiver stalls, the response register holds and the input
//   register still fills, so one more request is taken before req_stall
//   rises. Reset clears both valid flags and sets the clock to 12:00,
//   idle, 24-hour display.
// ----------------------------------------------------------------------------
module clock_time_set_and_display (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ctsd_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ctsd_pkg::rsp_type  rsp_data
);

   logic               in_valid_ff;
   ctsd_pkg::req_type  in_data_ff;
   logic               out_valid_ff;
   ctsd_pkg::rsp_type  out_data_ff;
   ctsd_pkg::rsp_type  out_data_in;
   ctsd_pkg::upd_type  upd;
   logic               out_free;
   logic               advance;

   assign out_free  = ~out_valid_ff | ~rsp_stall;
   assign advance   = in_valid_ff & out_free;
   assign req_stall = in_valid_ff & ~out_free;

   ctsd_update u_update (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (in_data_ff),
      .upd     (upd)
   );

   ctsd_display u_display (
      .upd (upd),
      .rsp (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (~req_stall)
            in_valid_ff <= req_valid;
         if (out_free)
            out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid & ~req_stall)
         in_data_ff <= req_data;
      if (advance)
         out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

// File: hdl/ctsd_update.sv
// ----------------------------------------------------------------------------
// ctsd_update
// Holds the clock digits, edit position and format, and applies one
// command per advance. Exposes the updated state and any rtc write.
// ----------------------------------------------------------------------------
module ctsd_update (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  ctsd_pkg::req_type   req,
   output ctsd_pkg::upd_type   upd
);

   ctsd_pkg::clock_state_type state_ff;
   ctsd_pkg::clock_state_type state_in;
   logic                      write_in;
   logic [4:0]                hour_clamp;
   logic [5:0]                minute_clamp;
   logic                      is_up;
   logic [2:0]                hour_tens;
   logic [3:0]                hour_units;

   always_comb begin
      hour_clamp   = (req.rtc_hour > ctsd_pkg::HOUR_MAX) ? ctsd_pkg::HOUR_MAX : req.rtc_hour;
      minute_clamp = (req.rtc_minute > ctsd_pkg::MINUTE_MAX) ? ctsd_pkg::MINUTE_MAX
                                                             : req.rtc_minute;
      is_up        = (req.cmd == ctsd_pkg::CMD_UP);
      state_in     = state_ff;
      write_in     = 1'b0;
      case (req.cmd)
         ctsd_pkg::CMD_TICK: begin
            if (state_ff.edit_step == ctsd_pkg::EDIT_IDLE) begin
               state_in.hour_value   = hour_clamp;
               state_in.minute_units = ctsd_pkg::units_of(minute_clamp);
               state_in.minute_tens  = ctsd_pkg::tens_of(minute_clamp);
            end
         end
         ctsd_pkg::CMD_SET: begin
            if (state_ff.edit_step == ctsd_pkg::EDIT_HOURS) begin
               state_in.edit_step = ctsd_pkg::EDIT_IDLE;
               write_in           = 1'b1;
            end else begin
               state_in.edit_step = ctsd_pkg::edit_type'(state_ff.edit_step + 2'd1);
            end
         end
         ctsd_pkg::CMD_UP, ctsd_pkg::CMD_DOWN: begin
            case (state_ff.edit_step)
               ctsd_pkg::EDIT_MIN_UNITS: begin
                  if (is_up)
                     state_in.minute_units = (state_ff.minute_units >= ctsd_pkg::UNITS_MAX)
                                             ? 4'd0 : state_ff.minute_units + 4'd1;
                  else
                     state_in.minute_units = (state_ff.minute_units == 4'd0)
                                             ? ctsd_pkg::UNITS_MAX
                                             : state_ff.minute_units - 4'd1;
               end
               ctsd_pkg::EDIT_MIN_TENS: begin
                  if (is_up)
                     state_in.minute_tens = (state_ff.minute_tens >= ctsd_pkg::TENS_MAX)
                                            ? 3'd0 : state_ff.minute_tens + 3'd1;
                  else
                     state_in.minute_tens = (state_ff.minute_tens == 3'd0)
                                            ? ctsd_pkg::TENS_MAX
                                            : state_ff.minute_tens - 3'd1;
               end
               ctsd_pkg::EDIT_HOURS: begin
                  if (is_up)
                     state_in.hour_value = (state_ff.hour_value >= ctsd_pkg::HOUR_MAX)
                                           ? 5'd0 : state_ff.hour_value + 5'd1;
                  else
                     state_in.hour_value = (state_ff.hour_value == 5'd0)
                                           ? ctsd_pkg::HOUR_MAX
                                           : state_ff.hour_value - 5'd1;
               end
               default: begin
               end
            endcase
         end
         ctsd_pkg::CMD_FORMAT: begin
            if (state_ff.edit_step == ctsd_pkg::EDIT_IDLE)
               state_in.twelve_hour_mode = ~state_ff.twelve_hour_mode;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.minute_units     <= 4'd0;
         state_ff.minute_tens      <= 3'd0;
         state_ff.hour_value       <= ctsd_pkg::HOUR_RESET;
         state_ff.edit_step        <= ctsd_pkg::EDIT_IDLE;
         state_ff.twelve_hour_mode <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // bcd write only on the set press that leaves edit mode
   always_comb begin
      hour_tens          = ctsd_pkg::tens_of(6'(state_ff.hour_value));
      hour_units         = ctsd_pkg::units_of(6'(state_ff.hour_value));
      upd.state          = state_in;
      upd.rtc_write      = write_in;
      upd.rtc_hour_bcd   = 6'd0;
      upd.rtc_minute_bcd = 7'd0;
      if (write_in) begin
         upd.rtc_hour_bcd   = {hour_tens[1:0], hour_units};
         upd.rtc_minute_bcd = {state_ff.minute_tens, state_ff.minute_units};
      end
   end

endmodule

// File: hdl/ctsd_display.sv
// ----------------------------------------------------------------------------
// ctsd_display
// Turns the updated clock state into seven-segment codes, the am/pm lamp
// and the edit position, and carries the rtc write through.
// ----------------------------------------------------------------------------
module ctsd_display (
   input  ctsd_pkg::upd_type  upd,
   output ctsd_pkg::rsp_type  rsp
);

   logic [4:0] shown;
   logic [1:0] lamp;

   always_comb begin
      shown = upd.state.hour_value;
      lamp  = ctsd_pkg::LAMP_OFF;
      if (upd.state.twelve_hour_mode) begin
         lamp = (upd.state.hour_value < ctsd_pkg::HOUR_NOON) ? ctsd_pkg::LAMP_AM
                                                            : ctsd_pkg::LAMP_PM;
         // midnight shows as 12, hours above 12 drop by 12
         if (upd.state.hour_value == 5'd0)
            shown = ctsd_pkg::HOUR_NOON;
         else if (upd.state.hour_value > ctsd_pkg::HOUR_NOON)
            shown = upd.state.hour_value - ctsd_pkg::HOUR_NOON;
      end

      rsp.seg_minute_units = ctsd_pkg::seg_code(upd.state.minute_units);
      rsp.seg_minute_tens  = ctsd_pkg::seg_code({1'b0, upd.state.minute_tens});
      rsp.seg_hour_units   = ctsd_pkg::seg_code(ctsd_pkg::units_of(6'(shown)))
                             | ctsd_pkg::DP_BIT;
      rsp.seg_hour_tens    = ctsd_pkg::seg_code({1'b0, ctsd_pkg::tens_of(6'(shown))});
      rsp.ampm_lamp        = lamp;
      rsp.edit_position    = upd.state.edit_step;
      rsp.rtc_write        = upd.rtc_write;
      rsp.rtc_hour_bcd     = upd.rtc_hour_bcd;
      rsp.rtc_minute_bcd   = upd.rtc_minute_bcd;
   end

endmodule

// File: verif/clock_time_set_and_display_tb.sv
// ----------------------------------------------------------------------------
// clock_time_set_and_display_tb
// Drives command requests (ticks, set, up, down, format toggle and unused
// codes) into the clock controller under random burst gaps and response
// stalls. A behavioral copy of the clock state predicts every display and
// rtc write response, which is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module clock_time_set_and_display_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] CMD_UNUSED_MID   = 3'd6;
   localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;
   localparam int REQUEST_COUNT  = 1000;
   localparam int HOLD_AFTER     = 300;
   localparam int HOLD_CYCLES    = 120;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ctsd_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   ctsd_pkg::rsp_type rsp_data;

   logic [7:0] digit_segments [10] = '{8'd63, 8'd6, 8'd91, 8'd79, 8'd102,
                                       8'd109, 8'd125, 8'd71, 8'd127, 8'd103};

   ctsd_pkg::req_type         command_q [$];
   ctsd_pkg::rsp_type         display_q [$];
   ctsd_pkg::clock_state_type clock_model;
   int                        errors = 0;

   // sender burst state
   int burst_left = 0;
   int gap_left = 0;
   // receiver stall state
   int responses_taken = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   logic holding_off = 1'b0;
   int run_left = 0;
   int stall_pct = 0;
   int idle_cycles = 0;

   clock_time_set_and_display uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // applies one command to the clock model and returns the display it shows
   function automatic ctsd_pkg::rsp_type predict_display(input ctsd_pkg::req_type r);
      ctsd_pkg::rsp_type  d;
      int                 hv;
      int                 mins;
      ctsd_pkg::lamp_type lamp;
      d = '0;
      case (r.cmd)
         ctsd_pkg::CMD_TICK: begin
            if (clock_model.edit_step == ctsd_pkg::EDIT_IDLE) begin
               hv = (r.rtc_hour > ctsd_pkg::HOUR_MAX) ? ctsd_pkg::HOUR_MAX : r.rtc_hour;
               mins = (r.rtc_minute > ctsd_pkg::MINUTE_MAX) ? ctsd_pkg::MINUTE_MAX
                                                            : r.rtc_minute;
               clock_model.hour_value = 5'(hv);
               clock_model.minute_units = 4'(mins % 10);
               clock_model.minute_tens = 3'(mins / 10);
            end
         end
         ctsd_pkg::CMD_SET: begin
            if (clock_model.edit_step == ctsd_pkg::EDIT_HOURS) begin
               clock_model.edit_step = ctsd_pkg::EDIT_IDLE;
               hv = clock_model.hour_value;
               d.rtc_write = 1'b1;
               d.rtc_hour_bcd = 6'((hv / 10) * 16 + hv % 10);
               d.rtc_minute_bcd = 7'(clock_model.minute_tens * 16 + clock_model.minute_units);
            end else begin
               clock_model.edit_step = ctsd_pkg::edit_type'(clock_model.edit_step + 2'd1);
            end
         end
         ctsd_pkg::CMD_UP, ctsd_pkg::CMD_DOWN: begin
            case (clock_model.edit_step)
               ctsd_pkg::EDIT_MIN_UNITS: begin
                  if (r.cmd == ctsd_pkg::CMD_UP)
                     clock_model.minute_units =
                        (clock_model.minute_units >= ctsd_pkg::UNITS_MAX) ?
                        4'd0 : clock_model.minute_units + 4'd1;
                  else
                     clock_model.minute_units = (clock_model.minute_units == 4'd0) ?
                        ctsd_pkg::UNITS_MAX : clock_model.minute_units - 4'd1;
               end
               ctsd_pkg::EDIT_MIN_TENS: begin
                  if (r.cmd == ctsd_pkg::CMD_UP)
                     clock_model.minute_tens =
                        (clock_model.minute_tens >= ctsd_pkg::TENS_MAX) ?
                        3'd0 : clock_model.minute_tens + 3'd1;
                  else
                     clock_model.minute_tens = (clock_model.minute_tens == 3'd0) ?
                        ctsd_pkg::TENS_MAX : clock_model.minute_tens - 3'd1;
               end
               ctsd_pkg::EDIT_HOURS: begin
                  if (r.cmd == ctsd_pkg::CMD_UP)
                     clock_model.hour_value =
                        (clock_model.hour_value >= ctsd_pkg::HOUR_MAX) ?
                        5'd0 : clock_model.hour_value + 5'd1;
                  else
                     clock_model.hour_value = (clock_model.hour_value == 5'd0) ?
                        ctsd_pkg::HOUR_MAX : clock_model.hour_value - 5'd1;
               end
               default: ;
            endcase
         end
         ctsd_pkg::CMD_FORMAT: begin
            if (clock_model.edit_step == ctsd_pkg::EDIT_IDLE)
               clock_model.twelve_hour_mode = ~clock_model.twelve_hour_mode;
         end
         default: ;
      endcase

      hv = clock_model.hour_value;
      lamp = ctsd_pkg::LAMP_OFF;
      if (clock_model.twelve_hour_mode) begin
         if (hv < ctsd_pkg::HOUR_NOON) lamp = ctsd_pkg::LAMP_AM;
         else lamp = ctsd_pkg::LAMP_PM;
         if (hv == 0) hv = 12;
         else if (hv > 12) hv = hv - 12;
      end
      d.seg_minute_units = digit_segments[clock_model.minute_units];
      d.seg_minute_tens = digit_segments[{1'b0, clock_model.minute_tens}];
      d.seg_hour_units = digit_segments[4'(hv % 10)] | ctsd_pkg::DP_BIT;
      d.seg_hour_tens = digit_segments[4'(hv / 10)];
      d.ampm_lamp = lamp;
      d.edit_position = clock_model.edit_step;
      return d;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   task automatic check_display(input ctsd_pkg::rsp_type want,
                                input ctsd_pkg::rsp_type got);
      check_field("seg_minute_units", want.seg_minute_units, got.seg_minute_units);
      check_field("seg_minute_tens", want.seg_minute_tens, got.seg_minute_tens);
      check_field("seg_hour_units", want.seg_hour_units, got.seg_hour_units);
      check_field("seg_hour_tens", want.seg_hour_tens, got.seg_hour_tens);
      check_field("ampm_lamp", want.ampm_lamp, got.ampm_lamp);
      check_field("edit_position", want.edit_position, got.edit_position);
      check_field("rtc_write", want.rtc_write, got.rtc_write);
      check_field("rtc_hour_bcd", want.rtc_hour_bcd, got.rtc_hour_bcd);
      check_field("rtc_minute_bcd", want.rtc_minute_bcd, got.rtc_minute_bcd);
   endtask

   task automatic add_request(input int c, input int h, input int m);
      ctsd_pkg::req_type r;
      r.cmd = 3'(c);
      r.rtc_hour = 5'(h);
      r.rtc_minute = 6'(m);
      command_q.push_back(r);
   endtask

   task automatic add_random_tick();
      int h;
      int m;
      // mostly legal rtc values, sometimes out of range
      h = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 23) : $urandom_range(24, 31);
      m = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 59) : $urandom_range(60, 63);
      add_request(ctsd_pkg::CMD_TICK, h, m);
   endtask

   // full walk through the three edit positions with random adjustments
   task automatic add_edit_session();
      int n;
      add_request(ctsd_pkg::CMD_SET, $urandom, $urandom);
      for (int stage = 0; stage < 3; stage++) begin
         n = $urandom_range(0, 14);
         repeat (n) begin
            case ($urandom_range(0, 9))
               0:          add_random_tick();
               1:          add_request(ctsd_pkg::CMD_FORMAT, $urandom, $urandom);
               2, 3, 4, 5: add_request(ctsd_pkg::CMD_UP, $urandom, $urandom);
               default:    add_request(ctsd_pkg::CMD_DOWN, $urandom, $urandom);
            endcase
         end
         add_request(ctsd_pkg::CMD_SET, $urandom, $urandom);
      end
   endtask

   // driver
   always @(posedge clock) begin : drive
      bit slot_free;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            display_q.push_back(predict_display(req_data));
         end
         slot_free = !req_valid || !req_stall;
         if (slot_free) begin
            if (burst_left == 0) begin
               if (holding_off) gap_left = 0;
               if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end
            end
            if (burst_left > 0 && command_q.size() > 0) begin
               req_data <= command_q.pop_front();
               req_valid <= 1'b1;
               burst_left--;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall pattern
   always @(posedge clock) begin : receive
      bit next_stall;
      if (reset) begin
         rsp_stall <= 1'b0;
         holding_off <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            responses_taken++;
            if (display_q.size() == 0) begin
               errors++;
               $display("%0t: response with none expected, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               check_display(display_q.pop_front(), rsp_data);
            end
         end
         if (!hold_done && responses_taken >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_stall = 1'b1;
         end else begin
            if (run_left == 0) begin
               run_left = $urandom_range(1, 40);
               case ($urandom_range(0, 2))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  default: stall_pct = 75;
               endcase
            end
            run_left--;
            next_stall = ($urandom_range(0, 99) < stall_pct);
         end
         rsp_stall <= next_stall;
         holding_off <= (hold_left > 0);
      end
   end

   // watchdog on cycles where neither channel moves
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no progress for %0d cycles", $time, idle_cycles);
               $display("[clock_time_set_and_display] ERROR");
               $finish;
            end
         end
      end
   end

   initial begin
      clock_model = '0;
      clock_model.hour_value = ctsd_pkg::HOUR_RESET;
      clock_model.edit_step = ctsd_pkg::EDIT_IDLE;

      // directed: clamping, 12-hour display corners, edit wraps, unused codes
      add_request(ctsd_pkg::CMD_TICK, 0, 0);
      add_request(ctsd_pkg::CMD_TICK, 23, 59);
      add_request(ctsd_pkg::CMD_TICK, 31, 63);
      add_request(ctsd_pkg::CMD_TICK, 24, 60);
      add_request(ctsd_pkg::CMD_UP, 31, 63);
      add_request(ctsd_pkg::CMD_DOWN, 0, 0);
      add_request(ctsd_pkg::CMD_FORMAT, 0, 0);
      add_request(ctsd_pkg::CMD_TICK, 0, 0);
      add_request(ctsd_pkg::CMD_TICK, 11, 5);
      add_request(ctsd_pkg::CMD_TICK, 12, 30);
      add_request(ctsd_pkg::CMD_TICK, 13, 45);
      add_request(ctsd_pkg::CMD_TICK, 23, 9);
      add_request(ctsd_pkg::CMD_TICK, 0, 0);
      add_request(ctsd_pkg::CMD_SET, 0, 0);
      add_request(ctsd_pkg::CMD_TICK, 10, 10);
      add_request(ctsd_pkg::CMD_FORMAT, 0, 0);
      add_request(ctsd_pkg::CMD_DOWN, 0, 0);
      add_request(ctsd_pkg::CMD_UP, 0, 0);
      add_request(ctsd_pkg::CMD_SET, 0, 0);
      add_request(ctsd_pkg::CMD_DOWN, 0, 0);
      add_request(ctsd_pkg::CMD_UP, 0, 0);
      add_request(ctsd_pkg::CMD_SET, 0, 0);
      add_request(ctsd_pkg::CMD_DOWN, 0, 0);
      add_request(ctsd_pkg::CMD_UP, 0, 0);
      add_request(CMD_UNUSED_FIRST, 31, 63);
      add_request(CMD_UNUSED_MID, 0, 0);
      add_request(CMD_UNUSED_LAST, 31, 63);
      add_request(ctsd_pkg::CMD_SET, 0, 0);
      add_request(ctsd_pkg::CMD_FORMAT, 0, 0);

      while (command_q.size() < REQUEST_COUNT) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: add_edit_session();
            4, 5, 6:    add_random_tick();
            7:          add_request(ctsd_pkg::CMD_FORMAT, $urandom, $urandom);
            default:    add_request($urandom_range(0, 7), $urandom, $urandom);
         endcase
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      wait (command_q.size() == 0 && !req_valid);
      wait (display_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0) begin
         $display("[clock_time_set_and_display] OK");
      end else begin
         $display("[clock_time_set_and_display] ERROR");
      end
      $finish;
   end

endmodule
